// ===== hdl/fmt7_pkg.sv =====
// ----------------------------------------------------------------------------
// fmt7_pkg
// Types, operation codes and the segment font shared by the four-digit
// seven-segment formatter.
// ----------------------------------------------------------------------------
`default_nettype none

package fmt7_pkg;

  localparam logic [1:0] OP_INTEGER = 2'd0;
  localparam logic [1:0] OP_TENTHS  = 2'd1;
  localparam logic [1:0] OP_RAW     = 2'd2;
  localparam logic [1:0] OP_CLEAR   = 2'd3;

  localparam logic [7:0]  SEG_POINT = 8'h80;
  localparam logic [7:0]  SEG_BLANK = 8'h00;
  localparam logic [15:0] VALUE_MAX = 16'd9999;
  localparam logic [2:0]  POS_MAX   = 3'd3;

  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_INVALID = 1'b1;

  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] number_value;
    logic        pad_zeros;
    logic [2:0]  digit_select;
    logic [7:0]  raw_segments;
    logic        point_on;
  } req_t;

  typedef struct packed {
    logic [1:0] position;
    logic [7:0] segment_byte;
    logic       status;
    logic       last;
  } rsp_t;

  // Per-transaction control that travels beside the digits through the pipe.
  typedef struct packed {
    logic [1:0] op;
    logic       invalid;
    logic       pad;
    logic [1:0] sel;
    logic [7:0] raw;
  } tok_t;

  typedef struct packed {
    logic [3:0] d0;
    logic [3:0] d1;
    logic [3:0] d2;
    logic [3:0] d3;
  } digits_t;

  function automatic logic [7:0] seg_font(input logic [3:0] d);
    logic [7:0] s;
    unique case (d)
      4'd0:    s = 8'h3F;
      4'd1:    s = 8'h06;
      4'd2:    s = 8'h5B;
      4'd3:    s = 8'h4F;
      4'd4:    s = 8'h66;
      4'd5:    s = 8'h6D;
      4'd6:    s = 8'h7D;
      4'd7:    s = 8'h07;
      4'd8:    s = 8'h7F;
      4'd9:    s = 8'h6F;
      default: s = 8'h00;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/fmt7_digits.sv =====
// ----------------------------------------------------------------------------
// fmt7_digits
// Six-stage pipeline that splits a value of 0 to 9999 into four decimal
// digits by reciprocal multiplication, alternating a constant product stage
// with a subtraction stage.
// ----------------------------------------------------------------------------
`default_nettype none

module fmt7_digits (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               advance,
  input  wire logic               in_valid,
  input  wire fmt7_pkg::tok_t     in_tok,
  input  wire logic [13:0]        in_value,
  output logic                    out_valid,
  output fmt7_pkg::tok_t          out_tok,
  output fmt7_pkg::digits_t       out_digits
);

  // Reciprocals are exact for the ranges that reach each stage.
  localparam logic [28:0] RECIP_1000 = 29'd16778;  // 2^24 / 1000, rounded up
  localparam logic [15:0] RECIP_100  = 16'd41;     // 2^12 / 100, rounded up
  localparam logic [13:0] RECIP_10   = 14'd103;    // 2^10 / 10, rounded up

  logic [5:0] stage_valid;
  fmt7_pkg::tok_t tok_a, tok_b, tok_c, tok_d, tok_e, tok_f;

  logic [13:0] value_a;
  logic [28:0] prod_a;
  logic [3:0]  d0_b, d0_c, d0_d, d0_e, d0_f;
  logic [9:0]  rem_b, rem_c;
  logic [15:0] prod_c;
  logic [3:0]  d1_d, d1_e, d1_f;
  logic [6:0]  rem_d, rem_e;
  logic [13:0] prod_e;
  logic [3:0]  d2_f, d3_f;

  logic [3:0]  d0_calc;
  logic [13:0] rem1_calc;
  logic [3:0]  d1_calc;
  logic [9:0]  rem2_calc;
  logic [3:0]  d2_calc;
  logic [6:0]  rem3_calc;

  always_comb begin
    d0_calc   = prod_a[27:24];
    rem1_calc = value_a - 14'(d0_calc) * 14'd1000;
    d1_calc   = prod_c[15:12];
    rem2_calc = rem_c - 10'(d1_calc) * 10'd100;
    d2_calc   = prod_e[13:10];
    rem3_calc = rem_e - 7'(d2_calc) * 7'd10;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= '0;
    end else if (advance) begin
      stage_valid <= {stage_valid[4:0], in_valid};
    end
    if (advance) begin
      tok_a   <= in_tok;
      value_a <= in_value;
      prod_a  <= 29'(in_value) * RECIP_1000;

      tok_b <= tok_a;
      d0_b  <= d0_calc;
      rem_b <= rem1_calc[9:0];

      tok_c  <= tok_b;
      d0_c   <= d0_b;
      rem_c  <= rem_b;
      prod_c <= 16'(rem_b) * RECIP_100;

      tok_d <= tok_c;
      d0_d  <= d0_c;
      d1_d  <= d1_calc;
      rem_d <= rem2_calc[6:0];

      tok_e  <= tok_d;
      d0_e   <= d0_d;
      d1_e   <= d1_d;
      rem_e  <= rem_d;
      prod_e <= 14'(rem_d) * RECIP_10;

      tok_f <= tok_e;
      d0_f  <= d0_e;
      d1_f  <= d1_e;
      d2_f  <= d2_calc;
      d3_f  <= rem3_calc[3:0];
    end
  end

  assign out_valid     = stage_valid[5];
  assign out_tok       = tok_f;
  assign out_digits.d0 = d0_f;
  assign out_digits.d1 = d1_f;
  assign out_digits.d2 = d2_f;
  assign out_digits.d3 = d3_f;

endmodule

`default_nettype wire

// ===== hdl/fmt7_serial.sv =====
// ----------------------------------------------------------------------------
// fmt7_serial
// Encodes the four digits of one transaction into segment bytes and plays
// them out as one or four digit writes, one per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module fmt7_serial (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  input  wire fmt7_pkg::tok_t    in_tok,
  input  wire fmt7_pkg::digits_t in_digits,
  output logic                   ready,
  output logic                   valid,
  output fmt7_pkg::rsp_t         result
);

  logic       active;
  logic [1:0] idx;
  logic       single;
  logic       status;
  logic [1:0] single_pos;
  logic [7:0] seg [4];

  logic       out_last;
  logic       load;
  logic [7:0] seg_next [4];
  logic       single_next;
  logic       status_next;
  logic [1:0] single_pos_next;
  logic       lead0, lead1, lead2;

  assign out_last = single || (idx == 2'd3);
  assign ready    = !active || out_last;
  assign load     = ready && in_valid;

  always_comb begin
    lead0 = (in_digits.d0 == 4'd0);
    lead1 = lead0 && (in_digits.d1 == 4'd0);
    lead2 = lead1 && (in_digits.d2 == 4'd0);
    for (int i = 0; i < 4; i++) begin
      seg_next[i] = fmt7_pkg::SEG_BLANK;
    end
    single_next     = 1'b0;
    status_next     = fmt7_pkg::STATUS_OK;
    single_pos_next = 2'd0;
    if (in_tok.invalid) begin
      single_next = 1'b1;
      status_next = fmt7_pkg::STATUS_INVALID;
    end else begin
      unique case (in_tok.op)
        fmt7_pkg::OP_INTEGER: begin
          seg_next[0] = (!in_tok.pad && lead0) ? fmt7_pkg::SEG_BLANK
                                               : fmt7_pkg::seg_font(in_digits.d0);
          seg_next[1] = (!in_tok.pad && lead1) ? fmt7_pkg::SEG_BLANK
                                               : fmt7_pkg::seg_font(in_digits.d1);
          seg_next[2] = (!in_tok.pad && lead2) ? fmt7_pkg::SEG_BLANK
                                               : fmt7_pkg::seg_font(in_digits.d2);
          seg_next[3] = fmt7_pkg::seg_font(in_digits.d3);
        end
        fmt7_pkg::OP_TENTHS: begin
          seg_next[0] = lead0 ? fmt7_pkg::SEG_BLANK : fmt7_pkg::seg_font(in_digits.d0);
          seg_next[1] = lead1 ? fmt7_pkg::SEG_BLANK : fmt7_pkg::seg_font(in_digits.d1);
          seg_next[2] = fmt7_pkg::seg_font(in_digits.d2) | fmt7_pkg::SEG_POINT;
          seg_next[3] = fmt7_pkg::seg_font(in_digits.d3);
        end
        fmt7_pkg::OP_RAW: begin
          single_next     = 1'b1;
          single_pos_next = in_tok.sel;
          seg_next[0]     = in_tok.raw;
        end
        fmt7_pkg::OP_CLEAR: begin
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      idx    <= 2'd0;
    end else if (load) begin
      active <= 1'b1;
      idx    <= 2'd0;
    end else if (active) begin
      if (out_last) begin
        active <= 1'b0;
      end
      idx <= idx + 2'd1;
    end
    if (load) begin
      for (int i = 0; i < 4; i++) begin
        seg[i] <= seg_next[i];
      end
      single     <= single_next;
      status     <= status_next;
      single_pos <= single_pos_next;
    end
  end

  assign valid               = active;
  assign result.position     = single ? single_pos : idx;
  assign result.segment_byte = seg[idx];
  assign result.status       = status;
  assign result.last         = out_last;

endmodule

`default_nettype wire

// ===== hdl/four_digit_seven_segment_formatter.sv =====
// ----------------------------------------------------------------------------
// four_digit_seven_segment_formatter
// Turns one display request into digit-register writes for a four-digit
// seven-segment display: integer, tenths, raw and clear modes.
// ----------------------------------------------------------------------------
//  Channel   Ports                      Transfer
//  request   start, busy, request       start high and busy low at a clock edge
//  result    valid, result              one cycle per write, cannot be held off
//
//  A request passes through the input register and the digit split pipeline,
//  then plays out one write per cycle: four for integer, tenths and clear, one
//  for raw and for an invalid request. The output sequencer takes the next
//  request while it plays out the last write of the current one.
//  Reset (rst, synchronous) empties the pipeline and the sequencer.
//  busy rises while the last pipeline stage holds a request and the sequencer
//  is still playing out an earlier one; a stalled pipeline holds every stage.
// ----------------------------------------------------------------------------
`default_nettype none

module four_digit_seven_segment_formatter (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  output logic                busy,
  input  wire fmt7_pkg::req_t request,
  output logic                valid,
  output fmt7_pkg::rsp_t      result
);

  logic           advance;
  logic           in_valid;
  fmt7_pkg::req_t in_req;
  fmt7_pkg::tok_t in_tok;

  logic              pipe_valid;
  fmt7_pkg::tok_t    pipe_tok;
  fmt7_pkg::digits_t pipe_digits;
  logic              ser_ready;

  assign advance = ser_ready || !pipe_valid;
  assign busy    = !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (advance) begin
      in_valid <= start;
    end
    if (advance) begin
      in_req <= request;
    end
  end

  always_comb begin
    in_tok.op      = in_req.op;
    in_tok.pad     = in_req.pad_zeros;
    in_tok.sel     = in_req.digit_select[1:0];
    in_tok.raw     = in_req.point_on ? (in_req.raw_segments | fmt7_pkg::SEG_POINT)
                                     : in_req.raw_segments;
    in_tok.invalid = ((in_req.op == fmt7_pkg::OP_INTEGER || in_req.op == fmt7_pkg::OP_TENTHS)
                      && (in_req.number_value > fmt7_pkg::VALUE_MAX))
                     || ((in_req.op == fmt7_pkg::OP_RAW)
                      && (in_req.digit_select > fmt7_pkg::POS_MAX));
  end

  fmt7_digits u_digits (
    .clk        (clk),
    .rst        (rst),
    .advance    (advance),
    .in_valid   (in_valid),
    .in_tok     (in_tok),
    .in_value   (in_req.number_value[13:0]),
    .out_valid  (pipe_valid),
    .out_tok    (pipe_tok),
    .out_digits (pipe_digits)
  );

  fmt7_serial u_serial (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (pipe_valid),
    .in_tok    (pipe_tok),
    .in_digits (pipe_digits),
    .ready     (ser_ready),
    .valid     (valid),
    .result    (result)
  );

  // A write that is not the final one of its transaction is followed at once
  // by the next position.
  a_burst_continues: assert property (@(posedge clk) disable iff (rst)
    valid && !result.last |=> valid && (result.position == 2'($past(result.position) + 2'd1)))
    else $error("digit write sequence broken");

  a_invalid_single: assert property (@(posedge clk) disable iff (rst)
    valid && (result.status == fmt7_pkg::STATUS_INVALID) |->
      result.last && (result.position == 2'd0) && (result.segment_byte == fmt7_pkg::SEG_BLANK))
    else $error("invalid status result malformed");

  a_busy_needs_work: assert property (@(posedge clk) disable iff (rst)
    busy |-> valid && !result.last)
    else $error("busy raised without a transaction in play");

endmodule

`default_nettype wire
